// ===== hw/rtl/lpt_pkg.sv =====
// Shared types, constants and escape-code table for the line prefix tagger.
// Used by lpt_ctrl, lpt_emit and line_prefix_tagger_top; no dependencies.
`default_nettype none

package lpt_pkg;

	localparam int PREFIX_MAX = 12;
	localparam int CHAR_W     = 16;
	localparam int MC_W       = $clog2(PREFIX_MAX + 1);
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CHAR_W-1:0] CHAR_LF = 16'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR = 16'd13;
	localparam logic [7:0]        CHAR_ESC = 8'd27;

	localparam logic [MC_W-1:0] COLOR_LEN = MC_W'(5);
	localparam logic [MC_W-1:0] RESET_LEN = MC_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_C  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRINT_EN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONLY_TAG  = 3'd5;

	typedef enum logic [1:0] {
		SEQ_GREEN = 2'd0,
		SEQ_GRAY  = 2'd1,
		SEQ_RESET = 2'd2
	} seq_t;

	typedef enum logic [4:0] {
		P_IDLE  = 5'b00001,
		P_COLOR = 5'b00010,
		P_HELD  = 5'b00100,
		P_CUR   = 5'b01000,
		P_RESET = 5'b10000
	} phase_t;

	// Output plan for one input word, in emission order.
	typedef struct packed {
		logic              color_en;
		logic              green;
		logic [MC_W-1:0]   held_n;
		logic              cur_en;
		logic [CHAR_W-1:0] cur_char;
		logic              reset_en;
	} plan_t;

	function automatic logic [CHAR_W-1:0] seq_unit(seq_t kind, logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case (idx)
			3'd0: c = CHAR_ESC;
			3'd1: c = "[";
			3'd2: c = (kind == SEQ_RESET) ? "0" : (kind == SEQ_GREEN) ? "3" : "9";
			3'd3: c = (kind == SEQ_RESET) ? "m" : (kind == SEQ_GREEN) ? "2" : "0";
			3'd4: c = "m";
			default: c = 8'h00;
		endcase
		return {8'h00, c};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/line_prefix_tagger_top.sv =====
// Line prefix tagger: an input word that produces output words keeps in_stall high
// until the output sequencer has loaded its last word; a word that produces none
// leaves in_stall low. The sequencer moves one word per cycle into the output register
// while out_stall allows it; the first word passes the phase register, then the output
// register. Reset is asynchronous, active low: empty prefix, print enabled, all lines
// shown, next word starts a line. Depends on lpt_pkg, lpt_ctrl, lpt_emit.
`default_nettype none

module line_prefix_tagger_top
	import lpt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [CHAR_W-1:0]    in_char,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CHAR_W-1:0]         out_char,
	output logic                      last
);

	logic              acc;
	logic              busy;
	plan_t             plan;
	logic [MC_W-1:0]   held_idx;
	logic [CHAR_W-1:0] held_data;

	assign in_stall = busy;
	assign acc      = in_valid && !busy;

	lpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.acc       (acc),
		.in_char   (in_char),
		.held_idx  (held_idx),
		.plan      (plan),
		.held_data (held_data)
	);

	lpt_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.plan      (plan),
		.held_data (held_data),
		.out_stall (out_stall),
		.held_idx  (held_idx),
		.busy      (busy),
		.out_valid (out_valid),
		.out_char  (out_char),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/lpt_ctrl.sv =====
// Configuration registers, line state, prefix compare and held-word buffer.
// Depends on lpt_pkg; hands an output plan to lpt_emit for each accepted word.
`default_nettype none

module lpt_ctrl
	import lpt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	input  wire logic                 acc,
	input  wire logic [CHAR_W-1:0]    in_char,
	input  wire logic [MC_W-1:0]      held_idx,
	output plan_t                     plan,
	output logic [CHAR_W-1:0]         held_data
);

	logic [CFG_W-1:0] pa_q, pb_q, pc_q;
	logic [3:0]       plen_q;
	logic             print_en_q;
	logic             only_tag_q;

	logic             at_start_q, deciding_q, tagged_q;
	logic [MC_W-1:0]  mc_q;
	logic [CHAR_W-1:0] held_q [PREFIX_MAX];

	logic             n_at_start, n_deciding, n_tagged;
	logic [MC_W-1:0]  n_mc;
	logic             hold_we;

	logic [MC_W-1:0]  eff_len;
	logic             ls, dec, tag, vis, is_lf;
	logic [MC_W-1:0]  mc;
	logic [3*CFG_W-1:0] pfx_all;
	logic [CHAR_W-1:0] unit_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q       <= '0;
			pb_q       <= '0;
			pc_q       <= '0;
			plen_q     <= '0;
			print_en_q <= 1'b1;
			only_tag_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PREFIX_A:   pa_q <= wr_data;
				REG_PREFIX_B:   pb_q <= wr_data;
				REG_PREFIX_C:   pc_q <= wr_data;
				REG_PREFIX_LEN: plen_q <= wr_data[3:0];
				REG_PRINT_EN:   print_en_q <= wr_data[0];
				REG_ONLY_TAG:   only_tag_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign eff_len = (plen_q > 4'(PREFIX_MAX)) ? MC_W'(PREFIX_MAX) : MC_W'(plen_q);
	assign pfx_all = {pc_q, pb_q, pa_q};
	assign ls      = at_start_q;
	assign dec     = ls ? (eff_len != '0) : deciding_q;
	assign tag     = ls ? 1'b0 : tagged_q;
	assign mc      = ls ? '0 : mc_q;
	assign is_lf   = (in_char == CHAR_LF);
	assign unit_sel = (mc < MC_W'(PREFIX_MAX)) ? pfx_all[{mc, 4'b0000} +: CHAR_W] : '0;

	always_comb begin
		n_at_start = at_start_q;
		n_deciding = deciding_q;
		n_tagged   = tagged_q;
		n_mc       = mc_q;
		hold_we    = 1'b0;
		vis        = 1'b0;
		plan       = '0;
		plan.cur_char = in_char;
		if (in_char != CHAR_CR && print_en_q) begin
			n_at_start = 1'b0;
			n_deciding = dec;
			n_tagged   = tag;
			n_mc       = mc;
			if (dec) begin
				if (is_lf || mc >= eff_len || in_char != unit_sel) begin
					vis = !only_tag_q;
					plan.color_en = vis;
					plan.green    = 1'b0;
					plan.held_n   = vis ? mc : '0;
					plan.cur_en   = vis;
					plan.reset_en = vis && is_lf;
					n_at_start = is_lf;
					n_deciding = is_lf;
					n_tagged   = 1'b0;
					n_mc       = '0;
				end else if (MC_W'(mc + 1'b1) == eff_len) begin
					plan.color_en = 1'b1;
					plan.green    = 1'b1;
					plan.held_n   = mc;
					plan.cur_en   = 1'b1;
					n_deciding = 1'b0;
					n_tagged   = 1'b1;
					n_mc       = '0;
				end else begin
					hold_we = 1'b1;
					n_mc    = MC_W'(mc + 1'b1);
				end
			end else begin
				vis = !only_tag_q || tag;
				plan.color_en = ls && (eff_len == '0) && !only_tag_q;
				plan.cur_en   = vis;
				if (is_lf) begin
					plan.reset_en = vis;
					n_at_start = 1'b1;
					n_deciding = 1'b1;
					n_tagged   = 1'b0;
					n_mc       = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			deciding_q <= 1'b0;
			tagged_q   <= 1'b0;
			mc_q       <= '0;
		end else if (acc) begin
			at_start_q <= n_at_start;
			deciding_q <= n_deciding;
			tagged_q   <= n_tagged;
			mc_q       <= n_mc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hold_we) begin
			held_q[mc] <= in_char;
		end
	end

	assign held_data = (held_idx < MC_W'(PREFIX_MAX)) ? held_q[held_idx] : '0;

`ifndef NO_ASSERTIONS
	a_mc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mc_q < MC_W'(PREFIX_MAX))
		else $error("match count beyond prefix buffer");

	a_mc_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!at_start_q && !deciding_q) |-> (mc_q == '0))
		else $error("match count left nonzero after decision");

	a_held_framed: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && plan.held_n != '0) |-> (plan.color_en && plan.cur_en))
		else $error("held words planned without color code and current word");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lpt_emit.sv =====
// Output sequencer: unless stalled, steps one word per cycle through color code, held words,
// current word and reset code. Depends on lpt_pkg; reads held words from lpt_ctrl.
`default_nettype none

module lpt_emit
	import lpt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire plan_t             plan,
	input  wire logic [CHAR_W-1:0] held_data,
	input  wire logic              out_stall,
	output logic [MC_W-1:0]        held_idx,
	output logic                   busy,
	output logic                   out_valid,
	output logic [CHAR_W-1:0]      out_char,
	output logic                   last
);

	phase_t            phase_q, after_cur, first_phase;
	plan_t             plan_q;
	logic [MC_W-1:0]   idx_q;
	logic              out_valid_q, out_last_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              load, done_now, last_next;
	logic [CHAR_W-1:0] word;

	function automatic phase_t after_phase(phase_t ph, plan_t p);
		phase_t nx;
		nx = P_IDLE;
		case (ph)
			P_COLOR: nx = (p.held_n != '0) ? P_HELD : p.cur_en ? P_CUR :
				p.reset_en ? P_RESET : P_IDLE;
			P_HELD:  nx = p.cur_en ? P_CUR : p.reset_en ? P_RESET : P_IDLE;
			P_CUR:   nx = p.reset_en ? P_RESET : P_IDLE;
			default: nx = P_IDLE;
		endcase
		return nx;
	endfunction

	assign first_phase = plan.color_en ? P_COLOR : after_phase(P_COLOR, plan);
	assign after_cur   = after_phase(phase_q, plan_q);

	always_comb begin
		done_now = 1'b0;
		word     = '0;
		case (phase_q)
			P_COLOR: begin
				done_now = (idx_q == MC_W'(COLOR_LEN - 1'b1));
				word = seq_unit(plan_q.green ? SEQ_GREEN : SEQ_GRAY, idx_q[2:0]);
			end
			P_HELD: begin
				done_now = (idx_q == MC_W'(plan_q.held_n - 1'b1));
				word = held_data;
			end
			P_CUR: begin
				done_now = 1'b1;
				word = plan_q.cur_char;
			end
			P_RESET: begin
				done_now = (idx_q == MC_W'(RESET_LEN - 1'b1));
				word = seq_unit(SEQ_RESET, idx_q[2:0]);
			end
			default: begin
				done_now = 1'b0;
				word = '0;
			end
		endcase
	end

	assign busy      = (phase_q != P_IDLE);
	assign load      = busy && (!out_valid_q || !out_stall);
	assign last_next = done_now && (after_cur == P_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			idx_q   <= '0;
		end else if (acc) begin
			phase_q <= first_phase;
			idx_q   <= '0;
		end else if (load) begin
			phase_q <= done_now ? after_cur : phase_q;
			idx_q   <= done_now ? '0 : MC_W'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			plan_q <= plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= word;
			out_last_q <= last_next;
		end
	end

	assign held_idx  = idx_q;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = out_last_q;

`ifndef NO_ASSERTIONS
	a_held_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_HELD) |-> (idx_q < plan_q.held_n))
		else $error("held index beyond held count");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && plan.cur_en) |=> (phase_q != P_IDLE))
		else $error("planned output not started");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_next) |=> (phase_q == P_IDLE && out_last_q && out_valid_q))
		else $error("sequencer still running after final word");
`endif

endmodule

`default_nettype wire

// ===== test/line_prefix_tagger_top_tb.sv =====
// Self-checking testbench for line_prefix_tagger_top: directed and random text lines
// against an in-bench tagger predictor, with random idling on both channels.
// Depends on lpt_pkg and line_prefix_tagger_top.
`timescale 1ns / 1ps

module line_prefix_tagger_top_tb;
	import lpt_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} tag_out_t;

	localparam logic [CHAR_W-1:0] ESC_UNIT     = 16'h001B;
	localparam logic [CHAR_W-1:0] BRACKET_UNIT = 16'h005B;
	localparam logic [CHAR_W-1:0] M_UNIT       = 16'h006D;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0]     wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CHAR_W-1:0]    in_char = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CHAR_W-1:0]    out_char;
	logic                 last;

	line_prefix_tagger_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_char  (in_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.last     (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the registers and the line state.
	logic [CFG_W-1:0]  cfg_pfx [3];
	logic [3:0]        cfg_len = 4'd0;
	logic              cfg_print = 1'b1;
	logic              cfg_only = 1'b0;
	logic              m_line_start = 1'b1;
	logic              m_deciding = 1'b0;
	logic              m_tagged = 1'b0;
	int                m_match = 0;
	logic [CHAR_W-1:0] m_held [PREFIX_MAX];

	logic [CHAR_W-1:0] step_out [$];
	tag_out_t          tagged_out_q [$];
	logic [CHAR_W-1:0] text_q [$];
	logic [CHAR_W-1:0] pfx_units [PREFIX_MAX];

	int words_sent = 0;
	int words_in = 0;
	int words_queued = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int errors = 0;
	int idle_pct = 20;
	logic hold_req = 1'b0;

	function automatic int eff_len();
		int n;
		n = cfg_len;
		if (n > 12) n = 12;
		if (n > PREFIX_MAX) n = PREFIX_MAX;
		return n;
	endfunction

	function automatic logic [CHAR_W-1:0] prefix_at(int i);
		return cfg_pfx[i / 4][(i % 4) * 16 +: 16];
	endfunction

	function automatic void add_step(logic [CHAR_W-1:0] u);
		step_out.insert(step_out.size(), u);
	endfunction

	function automatic void push_color(logic grn);
		add_step(ESC_UNIT);
		add_step(BRACKET_UNIT);
		add_step(grn ? 16'h0033 : 16'h0039);
		add_step(grn ? 16'h0032 : 16'h0030);
		add_step(M_UNIT);
	endfunction

	function automatic void close_decision(logic tag_on, logic [CHAR_W-1:0] ch);
		m_tagged = tag_on;
		m_deciding = 1'b0;
		if (!cfg_only || m_tagged) begin
			push_color(tag_on);
			for (int i = 0; i < m_match && i < PREFIX_MAX; i++)
				add_step(m_held[i]);
			add_step(ch);
		end
		m_match = 0;
	endfunction

	function automatic void close_line();
		if (!cfg_only || m_tagged) begin
			add_step(ESC_UNIT);
			add_step(BRACKET_UNIT);
			add_step(16'h0030);
			add_step(M_UNIT);
		end
		m_line_start = 1'b1;
		m_deciding = 1'b1;
		m_tagged = 1'b0;
		m_match = 0;
	endfunction

	function automatic void tag_predict(logic [CHAR_W-1:0] ch);
		int len;
		tag_out_t item;
		len = eff_len();
		step_out.delete();
		if (ch == CHAR_CR || !cfg_print)
			return;
		if (m_line_start) begin
			m_line_start = 1'b0;
			m_deciding = (len > 0);
			m_tagged = 1'b0;
			m_match = 0;
			if (len == 0 && !cfg_only)
				push_color(1'b0);
		end
		if (m_deciding) begin
			if (ch == CHAR_LF) begin
				close_decision(1'b0, ch);
				close_line();
			end else if (m_match >= len || ch != prefix_at(m_match)) begin
				close_decision(1'b0, ch);
			end else if (m_match + 1 == len) begin
				close_decision(1'b1, ch);
			end else begin
				m_held[m_match] = ch;
				m_match++;
			end
		end else begin
			if (!cfg_only || m_tagged)
				add_step(ch);
			if (ch == CHAR_LF)
				close_line();
		end
		foreach (step_out[i]) begin
			item.ch = step_out[i];
			item.last = (i == step_out.size() - 1);
			tagged_out_q.insert(tagged_out_q.size(), item);
		end
	endfunction

	// Acceptance of input words feeds the predictor; accepted output words are checked.
	always @(posedge clk) begin : watch_ports
		tag_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tag_predict(in_char);
				words_in++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (tagged_out_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual out_char %h last %b",
						$realtime, out_char, last);
				end else begin
					want = tagged_out_q.pop_front();
					if (want.ch !== out_char) begin
						errors++;
						$display("%0t: out_char mismatch, expected %h, actual %h",
							$realtime, want.ch, out_char);
					end
					if (want.last !== last) begin
						errors++;
						$display("%0t: last mismatch, expected %b, actual %b",
							$realtime, want.last, last);
					end
				end
			end
		end
	end

	always @(negedge clk) begin : drive_text
		logic nv;
		logic [CHAR_W-1:0] nc;
		int gap_left;
		if (arst_n) begin
			nv = in_valid;
			nc = in_char;
			if (in_valid && words_in == words_sent)
				nv = 1'b0;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
					gap_left = $urandom_range(9);
				end else if (text_q.size() > 0) begin
					nc = text_q.pop_front();
					nv = 1'b1;
					words_sent++;
				end
			end
			in_valid <= nv;
			in_char <= nc;
		end
	end

	always @(negedge clk) begin : drive_stall
		logic ns;
		int stall_left;
		int hold_left;
		logic hold_done;
		if (arst_n) begin
			ns = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else if (hold_req && hold_done !== 1'b1) begin
				hold_done = 1'b1;
				hold_left = 250;
				ns = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				ns = 1'b1;
			end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
				stall_left = $urandom_range(9);
				ns = 1'b1;
			end
			out_stall <= ns;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_PREFIX_A:   cfg_pfx[0] = data;
			REG_PREFIX_B:   cfg_pfx[1] = data;
			REG_PREFIX_C:   cfg_pfx[2] = data;
			REG_PREFIX_LEN: cfg_len = data[3:0];
			REG_PRINT_EN:   cfg_print = data[0];
			REG_ONLY_TAG:   cfg_only = data[0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic load_prefix();
		write_reg(REG_PREFIX_A, {pfx_units[3], pfx_units[2], pfx_units[1], pfx_units[0]});
		write_reg(REG_PREFIX_B, {pfx_units[7], pfx_units[6], pfx_units[5], pfx_units[4]});
		write_reg(REG_PREFIX_C, {pfx_units[11], pfx_units[10], pfx_units[9], pfx_units[8]});
	endtask

	task automatic queue_unit(logic [CHAR_W-1:0] u);
		text_q.insert(text_q.size(), u);
		words_queued++;
	endtask

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_unit({8'h00, s[i]});
	endtask

	task automatic wait_idle();
		while (text_q.size() != 0 || in_valid || tagged_out_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_text_unit();
		int r;
		r = $urandom_range(7);
		if (r < 2)
			return CHAR_W'($urandom());
		if (r == 2)
			return CHAR_CR;
		return 16'h0041 + CHAR_W'($urandom_range(25));
	endfunction

	function automatic logic [CHAR_W-1:0] random_prefix_unit();
		int r;
		r = $urandom_range(9);
		if (r < 7)
			return 16'h0041 + CHAR_W'($urandom_range(2));
		if (r < 9)
			return CHAR_W'($urandom());
		return CHAR_LF;
	endfunction

	task automatic queue_line();
		int plen;
		int n;
		plen = eff_len();
		case ($urandom_range(3))
			0, 1: begin
				for (int k = 0; k < plen; k++)
					queue_unit(pfx_units[k]);
			end
			2: begin
				n = (plen > 0) ? $urandom_range(plen - 1) : 0;
				for (int k = 0; k < n; k++)
					queue_unit(pfx_units[k]);
				queue_unit(pfx_units[n] ^ (16'h0001 << $urandom_range(15)));
			end
			default: ;
		endcase
		n = $urandom_range(6);
		repeat (n) queue_unit(random_text_unit());
		queue_unit(CHAR_LF);
	endtask

	initial begin : run_limit
		#4_000_000;
		$display("line_prefix_tagger_top verification failed");
		$finish;
	end

	initial begin : stimulus
		int target;
		int len_sel;
		for (int i = 0; i < 3; i++)
			cfg_pfx[i] = '0;
		for (int i = 0; i < PREFIX_MAX; i++) begin
			m_held[i] = '0;
			pfx_units[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty prefix after reset, with the extreme code units.
		queue_unit(16'hFFFF);
		queue_unit(16'h0000);
		queue_unit(CHAR_CR);
		queue_unit(CHAR_LF);
		wait_idle();

		pfx_units[0] = 16'h0049;
		pfx_units[1] = 16'h004E;
		pfx_units[2] = 16'h0046;
		pfx_units[3] = 16'h004F;
		load_prefix();
		write_reg(REG_PREFIX_LEN, 64'd4);
		queue_text("INFO\n");
		queue_text("IX\n");
		queue_text("I\rN\n");
		wait_idle();

		write_reg(REG_ONLY_TAG, 64'd1);
		queue_text("INFO\n");
		queue_text("Iz\n");
		wait_idle();

		write_reg(REG_PRINT_EN, 64'd0);
		queue_text("IN\n");
		wait_idle();
		write_reg(REG_PRINT_EN, 64'd1);
		write_reg(REG_ONLY_TAG, 64'd0);

		// Shorten the prefix while two words are held back.
		queue_text("IN");
		wait_idle();
		write_reg(REG_PREFIX_LEN, 64'd2);
		queue_text("F\n");
		wait_idle();

		// Oversized length saturates; a newline as the last prefix word ends untagged.
		for (int i = 0; i < PREFIX_MAX - 1; i++)
			pfx_units[i] = 16'h0061 + CHAR_W'(i);
		pfx_units[PREFIX_MAX - 1] = CHAR_LF;
		load_prefix();
		write_reg(REG_PREFIX_LEN, 64'd15);
		for (int i = 0; i < PREFIX_MAX; i++)
			queue_unit(pfx_units[i]);
		wait_idle();
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		queue_text("abc\n");
		wait_idle();

		for (int b = 0; b < 10; b++) begin
			for (int i = 0; i < PREFIX_MAX; i++)
				pfx_units[i] = random_prefix_unit();
			load_prefix();
			case (b)
				0: len_sel = 0;
				1: len_sel = 15;
				2: len_sel = 12;
				3: len_sel = 13;
				default: len_sel = $urandom_range(1, 5);
			endcase
			write_reg(REG_PREFIX_LEN, CFG_W'(len_sel));
			write_reg(REG_ONLY_TAG, CFG_W'(b % 3 == 1));
			write_reg(REG_PRINT_EN, CFG_W'(b != 5));
			idle_pct = (b == 4 || b == 9) ? 0 : 20;
			target = words_queued + 24;
			while (words_queued < target)
				queue_line();
			if (b == 3)
				hold_req = 1'b1;
			wait_idle();
		end

		$display("Run covered %0d text words across %0d register writes,", words_in, reg_writes);
		$display("with empty, partial, full and saturated prefixes; %0d output words checked.",
			results_seen);
		if (errors == 0)
			$display("line_prefix_tagger_top verification clean");
		else
			$display("line_prefix_tagger_top verification failed");
		$finish;
	end

endmodule
